### design/sqlhm_pkg.sv
// ----------------------------------------------------------------------------
// sqlhm_pkg
// Types and constants shared by the SyncE QL/holdover monitor and its checker.
// ----------------------------------------------------------------------------
package sqlhm_pkg;

    // DPLL states as seen on the request and stored for the result
    typedef enum logic [2:0] {
        ST_FREERUN  = 3'd0,
        ST_ACQ      = 3'd1,
        ST_LOCKED   = 3'd2,
        ST_HOLDOVER = 3'd3,
        ST_NONE     = 3'd4
    } pll_state_t;

    typedef enum logic [1:0] {
        ALARM_NONE    = 2'd0,
        ALARM_BAD_CLK = 2'd1,
        ALARM_BAD_SYNC = 2'd2
    } alarm_t;

    typedef enum logic {
        REQ_EVAL  = 1'b0,
        REQ_CLEAR = 1'b1
    } req_t;

    // register byte addresses divided by four
    typedef enum logic [1:0] {
        REG_LO_QL        = 2'd0,
        REG_HOLDOVER_QL  = 2'd1,
        REG_HOLDOVER_SEC = 2'd2,
        REG_ADVANCED     = 2'd3
    } reg_idx_t;

    localparam int QL_W       = 4;
    localparam int STATE_W    = 3;
    localparam int ALARM_W    = 2;
    localparam int NOW_W      = 47;
    localparam int DEADLINE_W = 48;
    localparam int HOLD_S_W   = 17;
    localparam int HOLD_MS_W  = 27;
    localparam int LEFT_W     = 32;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [QL_W-1:0] QL_NONE  = 4'd15;
    localparam logic [QL_W-1:0] QL_RESET = 4'd14;
    localparam int              MS_PER_S = 1000;

endpackage

### design/synce_quality_level_holdover_monitor_top.sv
// ----------------------------------------------------------------------------
// synce_quality_level_holdover_monitor_top
// Tracks the advertised SyncE DPLL state, QL and indices with a holdover timer.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a stalled result holds the pipeline, a
// rate set by the state update loop, which closes through the state registers
// alone: the new deadline is an add of now_ms and the precomputed timer length
// in milliseconds, and expiry compares now_ms against the old deadline. A
// request passes the input register, the state update and the result register
// and returns one result. The result stage derives the reported state and
// remaining holdover time from the stored state. The user must write registers
// over APB only while no request is in flight; the block itself does not
// enforce it. The timer length is converted to milliseconds at write time.
module synce_quality_level_holdover_monitor_top #(
    parameter int INDEX_BITS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    // req_type
    input  logic        s_tuser,
    // pll_state[2:0], tracked_clock, tracked_sync, tracked_ql[3:0], now_ms[46:0]
    input  logic [((3 + 2*INDEX_BITS + 4 + 47 + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // item_ignored, alarm_code[1:0], tx_ql_update, state_notify, ql_notify,
    // current_ql[3:0], reported_state[2:0], current_clock, current_sync,
    // holdover_left_ms[31:0]
    output logic [((45 + 2*INDEX_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqlhm_pkg::APB_AW-1:0]  paddr,
    input  logic [sqlhm_pkg::APB_DW-1:0]  pwdata,
    output logic [sqlhm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import sqlhm_pkg::*;

    localparam int IB          = INDEX_BITS;
    localparam int OUT_W       = 6 + QL_W + STATE_W + 2*IB + LEFT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int PST_LSB  = 0;
    localparam int CLK_LSB  = PST_LSB + STATE_W;
    localparam int SYNC_LSB = CLK_LSB + IB;
    localparam int QL_LSB   = SYNC_LSB + IB;
    localparam int NOW_LSB  = QL_LSB + QL_W;

    localparam logic [IB-1:0] IDX_INVALID = {IB{1'b1}};

    // ---------------- configuration ----------------
    logic [QL_W-1:0]      lo_ql_reg;
    logic [QL_W-1:0]      hold_ql_reg;
    logic [HOLD_S_W-1:0]  hold_s_reg;
    logic [HOLD_MS_W-1:0] hold_ms_reg;
    logic                 adv_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_ql_reg   <= QL_RESET;
            hold_ql_reg <= QL_RESET;
            hold_s_reg  <= '0;
            hold_ms_reg <= '0;
            adv_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LO_QL:        lo_ql_reg   <= pwdata[QL_W-1:0];
                REG_HOLDOVER_QL:  hold_ql_reg <= pwdata[QL_W-1:0];
                REG_HOLDOVER_SEC:
                begin
                    hold_s_reg  <= pwdata[HOLD_S_W-1:0];
                    hold_ms_reg <= HOLD_MS_W'(pwdata[HOLD_S_W-1:0])
                                   * HOLD_MS_W'(MS_PER_S);
                end
                REG_ADVANCED:     adv_reg     <= pwdata[0];
                default:          lo_ql_reg   <= lo_ql_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LO_QL:        prdata = APB_DW'(lo_ql_reg);
            REG_HOLDOVER_QL:  prdata = APB_DW'(hold_ql_reg);
            REG_HOLDOVER_SEC: prdata = APB_DW'(hold_s_reg);
            REG_ADVANCED:     prdata = APB_DW'(adv_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic en;

    // whole pipeline advances together whenever the result register is empty or taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- input register ----------------
    logic               s1_valid_reg;
    req_t               s1_req_reg;
    logic [STATE_W-1:0] s1_pst_reg;
    logic [IB-1:0]      s1_clk_reg;
    logic [IB-1:0]      s1_sync_reg;
    logic [QL_W-1:0]    s1_ql_reg;
    logic [NOW_W-1:0]   s1_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s_tvalid)
        begin
            s1_req_reg  <= req_t'(s_tuser);
            s1_pst_reg  <= s_tdata[PST_LSB +: STATE_W];
            s1_clk_reg  <= s_tdata[CLK_LSB +: IB];
            s1_sync_reg <= s_tdata[SYNC_LSB +: IB];
            s1_ql_reg   <= s_tdata[QL_LSB +: QL_W];
            s1_now_reg  <= s_tdata[NOW_LSB +: NOW_W];
        end
    end

    // ---------------- state update ----------------
    pll_state_t            state_reg, state_next;
    logic [QL_W-1:0]       ql_reg, ql_next;
    logic [IB-1:0]         clk_reg, clk_next;
    logic [IB-1:0]         sync_reg, sync_next;
    logic [DEADLINE_W-1:0] dl_reg, dl_next;

    logic            ign, txu, stn, qln, commit;
    alarm_t          alarm;
    logic [QL_W-1:0] worse_ql;
    logic [DEADLINE_W-1:0] now_ext;
    logic            past_dl;

    assign now_ext  = DEADLINE_W'(s1_now_reg);
    assign worse_ql = (ql_reg > hold_ql_reg) ? ql_reg : hold_ql_reg;
    assign past_dl  = now_ext > dl_reg;

    always_comb
    begin
        ign        = 1'b0;
        alarm      = ALARM_NONE;
        commit     = 1'b0;
        state_next = state_reg;
        ql_next    = ql_reg;
        clk_next   = IDX_INVALID;
        sync_next  = IDX_INVALID;
        dl_next    = dl_reg;
        if (s1_req_reg == REQ_CLEAR)
        begin
            if (hold_s_reg != '0)
            begin
                dl_next = '0;
            end
        end
        else
        begin
            case (s1_pst_reg)
                ST_ACQ, ST_LOCKED:
                begin
                    state_next = pll_state_t'(s1_pst_reg);
                    ql_next    = s1_ql_reg;
                    clk_next   = s1_clk_reg;
                    sync_next  = s1_sync_reg;
                    if (s1_clk_reg[IB-1])
                    begin
                        alarm = ALARM_BAD_CLK;
                        ign   = 1'b1;
                    end
                    else if (s1_sync_reg[IB-1])
                    begin
                        alarm = ALARM_BAD_SYNC;
                        ign   = 1'b1;
                    end
                    else if (s1_ql_reg == QL_NONE || s1_ql_reg > lo_ql_reg)
                    begin
                        ign = 1'b1;
                    end
                    commit = !ign;
                end
                ST_FREERUN:
                begin
                    state_next = ST_FREERUN;
                    ql_next    = lo_ql_reg;
                    commit     = 1'b1;
                end
                ST_HOLDOVER:
                begin
                    commit     = 1'b1;
                    state_next = ST_HOLDOVER;
                    // expiry is decided per case: a fresh deadline never lies behind now
                    case (state_reg)
                        ST_LOCKED:
                        begin
                            dl_next = now_ext + DEADLINE_W'(hold_ms_reg);
                            ql_next = worse_ql;
                        end
                        ST_HOLDOVER:
                        begin
                            ql_next = ql_reg;
                            if (past_dl)
                            begin
                                state_next = ST_FREERUN;
                                ql_next    = lo_ql_reg;
                            end
                        end
                        default:
                        begin
                            if (adv_reg)
                            begin
                                ql_next = worse_ql;
                                if (past_dl)
                                begin
                                    state_next = ST_FREERUN;
                                    ql_next    = lo_ql_reg;
                                end
                            end
                            else
                            begin
                                dl_next = '0;
                                ql_next = lo_ql_reg;
                                if (s1_now_reg != '0)
                                begin
                                    state_next = ST_FREERUN;
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                    ign = 1'b1;
                end
            endcase
        end
        txu = commit && (ql_next != ql_reg || clk_next != clk_reg || sync_next != sync_reg);
        stn = commit && (state_next != state_reg);
        qln = commit && (ql_next != ql_reg || sync_next != sync_reg);
    end

    logic upd;
    assign upd = s1_valid_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NONE;
            ql_reg    <= QL_NONE;
            clk_reg   <= IDX_INVALID;
            sync_reg  <= IDX_INVALID;
            dl_reg    <= '0;
        end
        else if (upd)
        begin
            dl_reg <= dl_next;
            if (commit)
            begin
                state_reg <= state_next;
                ql_reg    <= ql_next;
                clk_reg   <= clk_next;
                sync_reg  <= sync_next;
            end
        end
    end

    // ---------------- stage 2: flags held while status is formed ----------------
    logic             s2_valid_reg;
    logic             s2_ign_reg;
    alarm_t           s2_alarm_reg;
    logic             s2_txu_reg;
    logic             s2_stn_reg;
    logic             s2_qln_reg;
    logic [NOW_W-1:0] s2_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            s2_ign_reg   <= ign;
            s2_alarm_reg <= alarm;
            s2_txu_reg   <= txu;
            s2_stn_reg   <= stn;
            s2_qln_reg   <= qln;
            s2_now_reg   <= s1_now_reg;
        end
    end

    // state registers now hold the values left by the item in stage 2
    pll_state_t            rep_state;
    logic [LEFT_W-1:0]     left_ms;
    logic [DEADLINE_W-1:0] s2_now_ext;
    logic [DEADLINE_W-1:0] dl_diff;

    assign s2_now_ext = DEADLINE_W'(s2_now_reg);
    assign dl_diff    = dl_reg - s2_now_ext;

    always_comb
    begin
        rep_state = state_reg;
        left_ms   = '0;
        if (state_reg == ST_HOLDOVER)
        begin
            if (s2_now_ext >= dl_reg)
            begin
                rep_state = ST_FREERUN;
            end
            else
            begin
                left_ms = dl_diff[LEFT_W-1:0];
            end
        end
    end

    // ---------------- result register ----------------
    logic [OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg)
        begin
            out_data_reg <= {left_ms, sync_reg, clk_reg, rep_state, ql_reg,
                             s2_qln_reg, s2_stn_reg, s2_txu_reg, s2_alarm_reg, s2_ign_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

### design/sqlhm_checker.sv
// ----------------------------------------------------------------------------
// sqlhm_checker
// Port-level checks on the result stream of the QL/holdover monitor.
// ----------------------------------------------------------------------------
module sqlhm_checker #(
    parameter int INDEX_BITS = 7
) (
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((45 + 2*INDEX_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
    import sqlhm_pkg::*;

    localparam int IGN_BIT  = 0;
    localparam int ALM_LSB  = 1;
    localparam int TXU_BIT  = 3;
    localparam int STN_BIT  = 4;
    localparam int QLN_BIT  = 5;
    localparam int REP_LSB  = 6 + QL_W;
    localparam int LEFT_LSB = REP_LSB + STATE_W + 2*INDEX_BITS;

    logic               ign;
    logic [ALARM_W-1:0] alm;
    logic [STATE_W-1:0] rep;
    logic [LEFT_W-1:0]  left_ms;

    assign ign     = m_tdata[IGN_BIT];
    assign alm     = m_tdata[ALM_LSB +: ALARM_W];
    assign rep     = m_tdata[REP_LSB +: STATE_W];
    assign left_ms = m_tdata[LEFT_LSB +: LEFT_W];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // an alarm always comes with a rejected request
    a_alarm_ign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && alm != ALARM_NONE) |-> ign)
        else $error("alarm without ignore");

    // a rejected request changes nothing, so no change flags
    a_ign_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ign) |->
        (!m_tdata[TXU_BIT] && !m_tdata[STN_BIT] && !m_tdata[QLN_BIT]))
        else $error("change flag on ignored request");

    // remaining time only shows while holdover is reported
    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && rep != STATE_W'(ST_HOLDOVER)) |-> (left_ms == '0))
        else $error("holdover time outside holdover");

    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (rep <= STATE_W'(ST_NONE) && alm != 2'd3))
        else $error("reported state or alarm out of range");

endmodule

bind synce_quality_level_holdover_monitor_top sqlhm_checker #(
    .INDEX_BITS(INDEX_BITS)
) u_sqlhm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
